// ----- design/lbp_code_histogram_unit_defines.svh -----
// assertion macros shared by the lbp code histogram unit
`ifndef LBP_CODE_HISTOGRAM_UNIT_DEFINES_SVH
`define LBP_CODE_HISTOGRAM_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LBPH_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbph: assertion failed");
`define LBPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbph: assertion failed");
`else
`define LBPH_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define LBPH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/lbph_pkg.sv -----
// types, constants and helpers of the lbp code histogram unit
package lbph_pkg;
  localparam int MaxWidth     = 1024;
  localparam int MaxHeight    = 1024;
  localparam int CountBits    = 20;
  localparam int NumBins      = 256;
  localparam int ColBits      = $clog2(MaxWidth);
  localparam int RowBits      = $clog2(MaxHeight);
  localparam int SizeBits     = 11;
  localparam int CfgIndexBits = 2;
  localparam int QueueDepth   = 4;

  typedef logic [1:0]           cmd_t;
  typedef logic [7:0]           pixel_t;
  typedef logic [7:0]           bin_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [SizeBits-1:0]  size_t;
  typedef logic [ColBits-1:0]   col_t;
  typedef logic [RowBits-1:0]   row_t;
  typedef logic [ColBits:0]     width_t;
  typedef logic [RowBits:0]     height_t;
  typedef logic [CfgIndexBits-1:0] cfg_index_t;

  localparam cmd_t CmdPush  = 2'd0;
  localparam cmd_t CmdRead  = 2'd1;
  localparam cmd_t CmdClear = 2'd2;
  localparam cmd_t CmdNop   = 2'd3;

  localparam cfg_index_t CfgWidth  = 2'd0;
  localparam cfg_index_t CfgHeight = 2'd1;

  localparam size_t ResetWidth  = 11'd242;
  localparam size_t ResetHeight = 11'd393;

  localparam count_t CountMax = {CountBits{1'b1}};

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } op_kind_t;

  // one classified item from the front part to the histogram part
  typedef struct packed {
    op_kind_t kind;
    logic     code_valid;
    logic [7:0] value;
  } op_t;

  function automatic width_t clamp_width(size_t v);
    width_t r;
    if (32'(v) < 3) r = width_t'(3);
    else if (32'(v) > MaxWidth) r = width_t'(MaxWidth);
    else r = width_t'(v);
    return r;
  endfunction

  function automatic height_t clamp_height(size_t v);
    height_t r;
    if (32'(v) < 3) r = height_t'(3);
    else if (32'(v) > MaxHeight) r = height_t'(MaxHeight);
    else r = height_t'(v);
    return r;
  endfunction
endpackage

// ----- design/lbph_in_if.sv -----
// input channel: command, pixel and bin index with valid/ready
interface lbph_in_if;
  import lbph_pkg::*;
  logic   valid;
  logic   ready;
  cmd_t   cmd;
  pixel_t pixel;
  bin_t   bin_index;
  modport source (output valid, cmd, pixel, bin_index, input ready);
  modport sink (input valid, cmd, pixel, bin_index, output ready);
endinterface

// ----- design/lbph_out_if.sv -----
// output channel: code and bin count with valid/ready
interface lbph_out_if;
  import lbph_pkg::*;
  logic   valid;
  logic   ready;
  logic   code_valid;
  logic [7:0] lbp_code;
  count_t bin_count;
  modport source (output valid, code_valid, lbp_code, bin_count, input ready);
  modport sink (input valid, code_valid, lbp_code, bin_count, output ready);
endinterface

// ----- design/lbp_code_histogram_unit.sv -----
// Forms 3x3 local binary pattern codes from a raster pixel stream and counts them in a
// 256-bin histogram of 20-bit saturating counters. Every accepted item (push, read, clear,
// no-op) gives exactly one result, in order. The block sustains one item per clock while
// the receiver keeps ready high: the line buffers take one read and one write per cycle,
// and the bin memory does its read-modify-write with a bypass for back-to-back codes to
// the same bin. An item passes the line buffer read, the queue, the bin read and the
// result register in that order. The histogram memory is cleared through per-bin valid
// flags, so reset and the clear command take effect at once with no clearing pass.
// Image size registers are taken clamped to 3..1024 and should only be written while
// the block is idle.
module lbp_code_histogram_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  lbph_pkg::cfg_index_t cfg_index,
  input  lbph_pkg::size_t      cfg_data,
  lbph_in_if.sink              in_ch,
  lbph_out_if.source           out_ch
);
  import lbph_pkg::*;

  op_t  front_op;
  logic front_valid;
  logic front_ready;
  op_t  back_op;
  logic back_valid;
  logic back_ready;

  lbph_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .op        (front_op),
    .op_valid  (front_valid),
    .op_ready  (front_ready)
  );

  lbph_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_op     (front_op),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .out_op    (back_op),
    .out_valid (back_valid),
    .out_ready (back_ready)
  );

  lbph_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (back_op),
    .op_valid (back_valid),
    .op_ready (back_ready),
    .out_ch   (out_ch)
  );
endmodule

// ----- design/lbph_ram.sv -----
// generic simple dual port ram with registered read
module lbph_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  localparam int AddrBits = $clog2(Depth)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AddrBits-1:0] waddr,
  input  logic [Width-1:0]    wdata,
  input  logic                re,
  input  logic [AddrBits-1:0] raddr,
  output logic [Width-1:0]    rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ----- design/lbph_front.sv -----
// front part: config, raster position, line buffers, window and code forming
`include "lbp_code_histogram_unit_defines.svh"
module lbph_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  lbph_pkg::cfg_index_t cfg_index,
  input  lbph_pkg::size_t      cfg_data,
  lbph_in_if.sink              in_ch,
  output lbph_pkg::op_t        op,
  output logic                 op_valid,
  input  logic                 op_ready
);
  import lbph_pkg::*;

  width_t   width_eff;
  height_t  height_eff;
  col_t     col;
  row_t     row;
  width_t   col_inc;
  height_t  row_inc;
  op_kind_t kind_in;
  logic     accept;
  logic     line_re;
  logic     line_we;

  logic     s2_valid;
  op_kind_t s2_kind;
  logic     s2_interior;
  col_t     s2_col;
  pixel_t   s2_pixel;
  bin_t     s2_bin;
  logic     s2_fire;

  pixel_t   top;
  pixel_t   mid;
  pixel_t   win [6];
  logic [7:0] code;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= clamp_width(ResetWidth);
      height_eff <= clamp_height(ResetHeight);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgWidth:  width_eff  <= clamp_width(cfg_data);
        CfgHeight: height_eff <= clamp_height(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (in_ch.cmd)
      CmdPush:  kind_in = OP_PUSH;
      CmdRead:  kind_in = OP_READ;
      CmdClear: kind_in = OP_CLEAR;
      CmdNop:   kind_in = OP_NOP;
    endcase
  end

  assign s2_fire     = s2_valid && op_ready;
  assign in_ch.ready = !s2_valid || op_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign line_re     = accept && (kind_in == OP_PUSH);
  assign line_we     = s2_fire && (s2_kind == OP_PUSH);
  assign col_inc     = {1'b0, col} + width_t'(1);
  assign row_inc     = {1'b0, row} + height_t'(1);

  // raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (kind_in == OP_CLEAR) begin
        col <= '0;
        row <= '0;
      end else if (kind_in == OP_PUSH) begin
        if (col_inc >= width_eff) begin
          col <= '0;
          if (row_inc >= height_eff) row <= '0;
          else row <= row_inc[RowBits-1:0];
        end else begin
          col <= col_inc[ColBits-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (in_ch.ready) s2_valid <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_kind     <= kind_in;
      s2_interior <= (row >= row_t'(2)) && (col >= col_t'(2));
      s2_col      <= col;
      s2_pixel    <= in_ch.pixel;
      s2_bin      <= in_ch.bin_index;
    end
  end

  // row r-2
  lbph_ram #(.Width(8), .Depth(MaxWidth)) u_line_upper (
    .clk   (clk),
    .we    (line_we),
    .waddr (s2_col),
    .wdata (mid),
    .re    (line_re),
    .raddr (col),
    .rdata (top)
  );

  // row r-1
  lbph_ram #(.Width(8), .Depth(MaxWidth)) u_line_lower (
    .clk   (clk),
    .we    (line_we),
    .waddr (s2_col),
    .wdata (s2_pixel),
    .re    (line_re),
    .raddr (col),
    .rdata (mid)
  );

  // columns c-2 (0..2) and c-1 (3..5), rows top to bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (line_we) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= s2_pixel;
    end
  end

  // center is win[4]
  assign code = {win[0] >= win[4], win[3] >= win[4], top >= win[4], mid >= win[4],
                 s2_pixel >= win[4], win[5] >= win[4], win[2] >= win[4],
                 win[1] >= win[4]};

  assign op_valid      = s2_valid;
  assign op.kind       = s2_kind;
  assign op.code_valid = (s2_kind == OP_PUSH) && s2_interior;
  assign op.value      = (s2_kind == OP_PUSH) ? code : s2_bin;

  `LBPH_ASSERT_IMPLIES(a_line_addr_differs, clk, rst, line_we && line_re, s2_col != col)
endmodule

// ----- design/lbph_fifo.sv -----
// short queue between the front part and the histogram part
`include "lbp_code_histogram_unit_defines.svh"
module lbph_fifo (
  input  logic          clk,
  input  logic          rst,
  input  lbph_pkg::op_t in_op,
  input  logic          in_valid,
  output logic          in_ready,
  output lbph_pkg::op_t out_op,
  output logic          out_valid,
  input  logic          out_ready
);
  import lbph_pkg::*;

  localparam int PtrBits = $clog2(QueueDepth);

  op_t                entry [QueueDepth];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [PtrBits:0]   count;
  logic               push;
  logic               pop;

  assign in_ready  = count != (PtrBits+1)'(QueueDepth);
  assign out_valid = count != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_op    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PtrBits'(1);
      if (pop) rd_ptr <= rd_ptr + PtrBits'(1);
      if (push && !pop) count <= count + (PtrBits+1)'(1);
      else if (pop && !push) count <= count - (PtrBits+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= in_op;
  end

  `LBPH_ASSERT_IMPLIES(a_count_bound, clk, rst, out_valid, count <= (PtrBits+1)'(QueueDepth))
endmodule

// ----- design/lbph_back.sv -----
// histogram part: bin counters with read-modify-write and result register
`include "lbp_code_histogram_unit_defines.svh"
module lbph_back (
  input  logic          clk,
  input  logic          rst,
  input  lbph_pkg::op_t op,
  input  logic          op_valid,
  output logic          op_ready,
  lbph_out_if.source    out_ch
);
  import lbph_pkg::*;

  logic               w_valid;
  op_kind_t           w_kind;
  logic               w_code_valid;
  bin_t               w_addr;
  logic               w_hazard;
  count_t             w_bypass;
  logic               w_fire;
  logic               load;
  logic               bin_we;
  count_t             ram_q;
  count_t             count_cur;
  count_t             count_next;
  logic [NumBins-1:0] bin_valid;

  logic               out_valid;
  logic               out_code_valid;
  logic [7:0]         out_code;
  count_t             out_bin_count;

  assign w_fire   = w_valid && (!out_valid || out_ch.ready);
  assign op_ready = !w_valid || w_fire;
  assign load     = op_valid && op_ready;
  assign bin_we   = w_fire && (w_kind == OP_PUSH) && w_code_valid;

  // a bin never written since the last clear reads as zero
  assign count_cur  = w_hazard ? w_bypass : (bin_valid[w_addr] ? ram_q : '0);
  assign count_next = (count_cur == CountMax) ? count_cur : count_cur + count_t'(1);

  lbph_ram #(.Width(CountBits), .Depth(NumBins)) u_bins (
    .clk   (clk),
    .we    (bin_we),
    .waddr (w_addr),
    .wdata (count_next),
    .re    (load),
    .raddr (op.value),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else if (w_fire && (w_kind == OP_CLEAR)) begin
      bin_valid <= '0;
    end else if (bin_we) begin
      bin_valid[w_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) w_valid <= 1'b0;
    else if (op_ready) w_valid <= op_valid;
  end

  // ram read misses a write in the same cycle, so carry that value along
  always_ff @(posedge clk) begin
    if (load) begin
      w_kind       <= op.kind;
      w_code_valid <= op.code_valid;
      w_addr       <= op.value;
      w_hazard     <= bin_we && (w_addr == op.value);
      w_bypass     <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (w_fire) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (w_fire) begin
      out_code_valid <= bin_we;
      out_code       <= bin_we ? w_addr : '0;
      out_bin_count  <= (w_kind == OP_READ) ? count_cur : '0;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.code_valid = out_code_valid;
  assign out_ch.lbp_code   = out_code;
  assign out_ch.bin_count  = out_bin_count;

  `LBPH_ASSERT_NEXT(a_clear_empties, clk, rst, w_fire && (w_kind == OP_CLEAR), bin_valid == '0)
  `LBPH_ASSERT_IMPLIES(a_bypass_after_write, clk, rst, w_valid && w_hazard, bin_valid[w_addr])
  `LBPH_ASSERT_IMPLIES(a_code_no_count, clk, rst, out_valid && out_code_valid, out_bin_count == '0)
endmodule

// ----- tb/tb_lbp_code_histogram_unit.sv -----
// testbench for the lbp code histogram unit: directed frames, random streams, back pressure
module tb_lbp_code_histogram_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import lbph_pkg::*;

  localparam cfg_index_t CfgSpare0 = 2'd2;
  localparam cfg_index_t CfgSpare1 = 2'd3;
  localparam bin_t DirCode = 8'hBA;   // code of the first directed window
  localparam int StallLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int RandomItems = 1300;
  // two 3x3 frames, raster order
  localparam logic [18*8-1:0] DirPixels = {
    8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 8'd255, 8'd255, 8'd0, 8'd128,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};

  typedef struct packed {
    cmd_t   cmd;
    pixel_t pixel;
    bin_t   bin_index;
  } lbp_item_t;

  typedef struct packed {
    logic       code_valid;
    logic [7:0] lbp_code;
    count_t     bin_count;
  } lbp_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  cfg_index_t cfg_index;
  size_t cfg_data;

  lbph_in_if  in_ch ();
  lbph_out_if out_ch ();

  lbp_code_histogram_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #2 clk = ~clk;

  // predicted block state
  size_t       width_reg, height_reg;
  pixel_t      row_above2 [MaxWidth];
  pixel_t      row_above1 [MaxWidth];
  pixel_t      win [6];
  int unsigned raster_col, raster_row;
  count_t      code_hist [NumBins];
  bin_t        recent_code;

  // raster tracking on the stimulus side, keeps codes away from unwritten line entries
  int unsigned trk_col, trk_row, trk_w, trk_h;
  logic [1:0]  writes_at [MaxWidth];
  logic        win_ok1, win_ok2;

  lbp_item_t   cmd_stream [$];
  lbp_result_t predicted_codes [$];

  logic src_idle_on, snk_idle_on, hold_go, hold_done;
  int   src_gap, snk_gap, hold_left, stuck_cycles;
  int   fail_count, reports, results_checked, codes_checked;
  int   n_push, n_read, n_clear, n_nop;

  function automatic int unsigned eff_size(size_t v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic lbp_result_t compute_lbp_result(lbp_item_t itm);
    lbp_result_t r;
    int unsigned w, h, c;
    int b;
    pixel_t top, mid, ctr;
    bin_t code;
    r = '0;
    case (itm.cmd)
      CmdRead: r.bin_count = code_hist[itm.bin_index];
      CmdClear: begin
        for (b = 0; b < NumBins; b++) code_hist[b] = '0;
        raster_col = 0;
        raster_row = 0;
      end
      CmdPush: begin
        w = eff_size(width_reg, MaxWidth);
        h = eff_size(height_reg, MaxHeight);
        c = raster_col % MaxWidth;
        top = row_above2[c];
        mid = row_above1[c];
        ctr = win[4];
        if (raster_row >= 2 && c >= 2) begin
          code = {win[0] >= ctr, win[3] >= ctr, top >= ctr, mid >= ctr,
                  itm.pixel >= ctr, win[5] >= ctr, win[2] >= ctr, win[1] >= ctr};
          if (code_hist[code] != CountMax) code_hist[code] = code_hist[code] + 1'b1;
          r.code_valid = 1'b1;
          r.lbp_code = code;
          recent_code = code;
        end
        row_above2[c] = mid;
        row_above1[c] = itm.pixel;
        win[0] = win[3];
        win[1] = win[4];
        win[2] = win[5];
        win[3] = top;
        win[4] = mid;
        win[5] = itm.pixel;
        if (c + 1 >= w) begin
          raster_col = 0;
          raster_row = (raster_row + 1 >= h) ? 0 : raster_row + 1;
        end else begin
          raster_col = c + 1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pixel_t pick_pixel(int mode, pixel_t base);
    if (mode == 0) return pixel_t'($urandom_range(0, 255));
    if (mode == 1) return base + pixel_t'($urandom_range(0, 3));  // many ties with the center
    return $urandom_range(0, 1) ? 8'd255 : 8'd0;
  endfunction

  task automatic enqueue_item(cmd_t cmd, pixel_t pix, bin_t bin);
    lbp_item_t itm;
    logic rd_ok;
    itm.cmd = cmd;
    itm.pixel = pix;
    itm.bin_index = bin;
    while (cmd_stream.size() >= 32) @(negedge clk);
    cmd_stream.push_back(itm);
    case (cmd)
      CmdPush: begin
        n_push++;
        rd_ok = writes_at[trk_col] >= 2;
        if (writes_at[trk_col] != 2'd2) writes_at[trk_col] = writes_at[trk_col] + 1'b1;
        win_ok2 = win_ok1;
        win_ok1 = rd_ok;
        if (trk_col + 1 >= trk_w) begin
          trk_col = 0;
          trk_row = (trk_row + 1 >= trk_h) ? 0 : trk_row + 1;
        end else begin
          trk_col = trk_col + 1;
        end
      end
      CmdClear: begin
        n_clear++;
        trk_col = 0;
        trk_row = 0;
      end
      CmdRead: n_read++;
      default: n_nop++;
    endcase
  endtask

  task automatic enqueue_pixel(pixel_t pix);
    // a code built from a line entry never written restarts the raster first
    if (trk_row >= 2 && trk_col >= 2 && !(writes_at[trk_col] >= 2 && win_ok1 && win_ok2))
      enqueue_item(CmdClear, pixel_t'($urandom_range(0, 255)), bin_t'($urandom_range(0, 255)));
    enqueue_item(CmdPush, pix, bin_t'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(cfg_index_t idx, size_t val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CfgWidth: begin
        width_reg = val;
        trk_w = eff_size(val, MaxWidth);
      end
      CfgHeight: begin
        height_reg = val;
        trk_h = eff_size(val, MaxHeight);
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (cmd_stream.size() != 0 || in_ch.valid || predicted_codes.size() != 0)
      @(negedge clk);
  endtask

  // input side: one item per transfer, predicted on acceptance
  always @(posedge clk) begin : drive_items
    lbp_item_t taken, nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.cmd = in_ch.cmd;
        taken.pixel = in_ch.pixel;
        taken.bin_index = in_ch.bin_index;
        predicted_codes.push_back(compute_lbp_result(taken));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap != 0) begin
          in_ch.valid <= 1'b0;
          src_gap <= src_gap - 1;
        end else if (cmd_stream.size() != 0) begin
          nxt = cmd_stream.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= nxt.cmd;
          in_ch.pixel <= nxt.pixel;
          in_ch.bin_index <= nxt.bin_index;
          src_gap <= src_idle_on ? gap_len() : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started once on request
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output side: compare each result transfer with the oldest prediction
  always @(posedge clk) begin : check_results
    lbp_result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      snk_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (predicted_codes.size() == 0) begin
          fail_count++;
          if (reports < 10) $display("unexpected result: code_valid=%0d code=%02h count=%0d",
                                     out_ch.code_valid, out_ch.lbp_code, out_ch.bin_count);
          reports++;
        end else begin
          want = predicted_codes.pop_front();
          if (out_ch.code_valid !== want.code_valid || out_ch.lbp_code !== want.lbp_code ||
              out_ch.bin_count !== want.bin_count) begin
            fail_count++;
            if (reports < 10)
              $display("result %0d: expected valid=%0d code=%02h count=%0d, got valid=%0d code=%02h count=%0d",
                       results_checked, want.code_valid, want.lbp_code, want.bin_count,
                       out_ch.code_valid, out_ch.lbp_code, out_ch.bin_count);
            reports++;
          end
          results_checked++;
          if (want.code_valid) codes_checked++;
        end
      end
      if (hold_left != 0 || snk_gap != 0) begin
        out_ch.ready <= 1'b0;
        if (snk_gap != 0) snk_gap <= snk_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (snk_idle_on && $urandom_range(0, 2) == 0) snk_gap <= gap_len();
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == StallLimit) begin
        $display("watchdog: no transfer in %0d cycles", StallLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int k, len, phase, done_items, r, pix_mode;
    pixel_t base;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CfgWidth;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CmdNop;
    in_ch.pixel = '0;
    in_ch.bin_index = '0;
    out_ch.ready = 1'b0;
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    hold_go = 1'b0;
    fail_count = 0;
    reports = 0;
    results_checked = 0;
    codes_checked = 0;
    n_push = 0;
    n_read = 0;
    n_clear = 0;
    n_nop = 0;
    width_reg = ResetWidth;
    height_reg = ResetHeight;
    trk_w = eff_size(ResetWidth, MaxWidth);
    trk_h = eff_size(ResetHeight, MaxHeight);
    raster_col = 0;
    raster_row = 0;
    trk_col = 0;
    trk_row = 0;
    win_ok1 = 1'b0;
    win_ok2 = 1'b0;
    recent_code = '0;
    for (k = 0; k < MaxWidth; k++) begin
      row_above2[k] = '0;
      row_above1[k] = '0;
      writes_at[k] = '0;
    end
    for (k = 0; k < 6; k++) win[k] = '0;
    for (k = 0; k < NumBins; k++) code_hist[k] = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset sizes, then a clamped 3x3 image, two frames
    enqueue_item(CmdNop, 8'hFF, 8'hFF);
    enqueue_item(CmdRead, 8'h00, 8'h00);
    enqueue_pixel(8'hFF);
    wait_drained();
    write_reg(CfgWidth, 11'd0);
    write_reg(CfgHeight, 11'd2);
    write_reg(CfgSpare0, 11'h7FF);
    write_reg(CfgSpare1, 11'h7FF);
    enqueue_item(CmdClear, 8'h00, 8'h00);
    for (k = 0; k < 18; k++) enqueue_pixel(DirPixels[(17 - k) * 8 +: 8]);
    enqueue_item(CmdRead, 8'h00, DirCode);
    enqueue_item(CmdRead, 8'h00, 8'h00);
    enqueue_item(CmdClear, 8'hFF, 8'hFF);
    enqueue_item(CmdRead, 8'h00, DirCode);

    // random phases with narrow images, sizes changed between phases
    done_items = 0;
    phase = 0;
    while (done_items < RandomItems) begin
      wait_drained();
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 9);
        write_reg(CfgWidth, size_t'(r == 0 ? $urandom_range(0, 2) :
                                    r == 1 ? $urandom_range(20, 70) : $urandom_range(3, 12)));
      end
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        r = $urandom_range(0, 9);
        write_reg(CfgHeight, size_t'(r == 0 ? $urandom_range(0, 2) :
                                     r == 1 ? $urandom_range(1025, 2047) :
                                              $urandom_range(3, 8)));
      end
      if ($urandom_range(0, 1)) enqueue_item(CmdClear, pixel_t'($urandom_range(0, 255)),
                                             bin_t'($urandom_range(0, 255)));
      src_idle_on = (phase == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      snk_idle_on = $urandom_range(0, 3) != 0;
      if (phase == 2) hold_go = 1'b1;
      pix_mode = $urandom_range(0, 2);
      base = pixel_t'($urandom_range(0, 255));
      len = (phase == 2) ? 200 : $urandom_range(60, 150);
      for (k = 0; k < len; k++) begin
        // in phase 4 the sender waits for every outstanding result mid-phase
        if (phase == 4 && k == len / 2) wait_drained();
        r = $urandom_range(0, 99);
        if (r < 80) enqueue_pixel(pick_pixel(pix_mode, base));
        else if (r < 89) enqueue_item(CmdRead, pixel_t'($urandom_range(0, 255)),
                                      $urandom_range(0, 1) ? recent_code :
                                                             bin_t'($urandom_range(0, 255)));
        else if (r < 92) enqueue_item(CmdClear, pixel_t'($urandom_range(0, 255)),
                                      bin_t'($urandom_range(0, 255)));
        else enqueue_item(CmdNop, pixel_t'($urandom_range(0, 255)),
                          bin_t'($urandom_range(0, 255)));
        done_items++;
      end
      phase++;
    end

    wait_drained();
    repeat (12) @(posedge clk);
    $display("stimulus: %0d pushes, %0d reads, %0d clears, %0d no-ops; %0d results, %0d codes checked",
             n_push, n_read, n_clear, n_nop, results_checked, codes_checked);
    $display("image sizes from clamped 3x3 up to 70 wide, mid-frame resizes, frame wraps, stalls");
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
